// ===== sv/bba_pkg.sv =====
`timescale 1ns / 1ps
package bba_pkg;

  localparam int unsigned MAP_DEPTH_DEF = 32768;

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  localparam logic CFG_BASE    = 1'b0;
  localparam logic CFG_MANAGED = 1'b1;

  localparam logic [15:0] MANAGED_RST = 16'd32768;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOSPACE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_QUERY  = 2'd2,
    OP_REJECT = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] block_number;
    logic [15:0] run_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] first_block;
    logic [15:0] granted_count;
    logic        in_use;
    logic [15:0] free_remaining;
  } out_item_t;

  // classified request between front and back
  typedef struct packed {
    op_e         op;
    logic [15:0] off;
    logic [15:0] cnt;
  } cmd_t;

  function automatic logic [15:0] eff_calc(logic [15:0] managed, int unsigned depth);
    logic [15:0] r;
    if (32'(managed) < depth) r = managed;
    else r = 16'(depth);
    return r;
  endfunction

  function automatic logic [15:0] free_left(logic [15:0] eff, logic [15:0] used);
    logic [15:0] r;
    if (eff > used) r = eff - used;
    else r = '0;
    return r;
  endfunction

endpackage

// ===== sv/bitmap_block_allocator.sv =====
`timescale 1ns / 1ps
// Bitmap block allocator, first-fit runs.
// Requests enter through a queue port: write in_item_i with push while full
// is low. Results leave through a queue port: while empty is low the oldest
// result is on out_item_o, and pop takes it. Every request yields exactly
// one result, in request order.
// Configuration (base_block, managed_blocks) goes over the always-ready cfg port;
// the user must write it only while no request is in flight (not enforced).
// After reset the map is swept clear one 32-bit word a cycle, ceil(MapDepth/32)
// words (1024 by default), with full held high the whole time.
// Engine work per request, set by the single map port and one word per access:
//   rejected request or allocate with too few free blocks: answered from idle
//   query: one read of the word holding the block
//   allocate: scan words until a run fits, then read-modify-write each word marked
//   free: check each word of the run is in use, then read-modify-write each word
// A result can be popped in the cycle after the engine finishes with it; the engine
// picks a request up once it is idle and the result queue has room.
// A two-deep request queue and a two-deep result queue sit on either side,
// so a stalled receiver only stops the engine once both results are waiting.
module bitmap_block_allocator #(
  parameter int unsigned MapDepth = bba_pkg::MAP_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  bba_pkg::in_item_t  in_item_i,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output bba_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import bba_pkg::*;

  logic [31:0] base_q;
  logic [15:0] managed_q;
  logic [15:0] eff;
  cmd_t        cmd;
  logic        cmd_empty, cmd_pop, front_full, init;
  logic        res_push, res_full;
  out_item_t   res;

  assign cfg_ready_o = 1'b1;
  assign eff         = eff_calc(managed_q, MapDepth);
  assign full        = front_full || init;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      managed_q <= MANAGED_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BASE:    base_q    <= cfg_data_i;
        CFG_MANAGED: managed_q <= cfg_data_i[15:0];
        default:     base_q    <= base_q;
      endcase
    end
  end

  bba_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push && !init),
    .item_i      (in_item_i),
    .full_o      (front_full),
    .base_i      (base_q),
    .eff_i       (eff),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd),
    .cmd_empty_o (cmd_empty)
  );

  bba_back #(.MapDepth(MapDepth)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .base_i      (base_q),
    .eff_i       (eff),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res),
    .init_o      (init)
  );

  bba_fifo #(.T(out_item_t)) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .rd_i    (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

endmodule

// ===== sv/bba_fifo.sv =====
`timescale 1ns / 1ps
module bba_fifo #(
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  T     data_i,
  output logic full_o,
  input  logic rd_i,
  output T     data_o,
  output logic empty_o
);

  T           mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_wr, do_rd;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_wr) wp_q <= !wp_q;
      if (do_rd) rp_q <= !rp_q;
      if (do_wr && !do_rd) cnt_q <= cnt_q + 2'd1;
      else if (do_rd && !do_wr) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

// ===== sv/bba_front.sv =====
`timescale 1ns / 1ps
module bba_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bba_pkg::in_item_t item_i,
  output logic              full_o,
  input  logic [31:0]       base_i,
  input  logic [15:0]       eff_i,
  input  logic              cmd_pop_i,
  output bba_pkg::cmd_t     cmd_o,
  output logic              cmd_empty_o
);
  import bba_pkg::*;

  cmd_t        cmd;
  logic        ge_base;
  logic [33:0] run_end, lim;
  logic        free_ok, query_ok;

  // range checks are 34 bits wide so nothing wraps
  assign ge_base  = item_i.block_number >= base_i;
  assign run_end  = 34'(item_i.block_number) + 34'(item_i.run_count);
  assign lim      = 34'(base_i) + 34'(eff_i);
  assign free_ok  = (item_i.run_count != '0) && ge_base && (run_end <= lim);
  assign query_ok = ge_base && (34'(item_i.block_number) < lim);

  always_comb begin
    cmd.off = 16'(item_i.block_number - base_i);
    cmd.cnt = item_i.run_count;
    cmd.op  = OP_REJECT;
    unique case (item_i.action)
      ACT_ALLOC: if (item_i.run_count != '0) cmd.op = OP_ALLOC;
      ACT_FREE:  if (free_ok) cmd.op = OP_FREE;
      ACT_QUERY: if (query_ok) cmd.op = OP_QUERY;
      default:   cmd.op = OP_REJECT;
    endcase
  end

  bba_fifo #(.T(cmd_t)) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push_i),
    .data_i  (cmd),
    .full_o  (full_o),
    .rd_i    (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (cmd_empty_o)
  );

endmodule

// ===== sv/bba_back.sv =====
`timescale 1ns / 1ps
module bba_back #(
  parameter int unsigned MapDepth = bba_pkg::MAP_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [31:0]        base_i,
  input  logic [15:0]        eff_i,
  input  bba_pkg::cmd_t      cmd_i,
  input  logic               cmd_empty_i,
  output logic               cmd_pop_o,
  input  logic               res_full_i,
  output logic               res_push_o,
  output bba_pkg::out_item_t res_o,
  output logic               init_o
);
  import bba_pkg::*;

  localparam int unsigned Words = (MapDepth + 31) / 32;
  localparam int unsigned AW    = $clog2(Words);
  localparam int unsigned IW    = (AW + 6 > 17) ? AW + 6 : 17;
  localparam int unsigned WW    = IW - 5;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_WR    = 3'd5;
  localparam logic [2:0] S_QUERY = 3'd6;

  logic [31:0] mem [Words];
  logic [31:0] rdata_q;

  logic [2:0]    state_q, state_d;
  logic [WW-1:0] w_q, w_d;
  logic          rv_q, rv_d;
  logic [WW-1:0] rw_q, rw_d;
  logic [IW-1:0] carry_q, carry_d;
  logic [IW-1:0] lo_q, lo_d;
  logic [15:0]   cnt_q, cnt_d;
  op_e           op_q, op_d;
  logic [15:0]   used_q, used_d;

  logic          re, we;
  logic [AW-1:0] ra, wa;
  logic [31:0]   wd;

  logic [IW-1:0] eff_ext, nw_tmp, hi, hi_m1, off_ext, run_start;
  logic [WW-1:0] last_w, lo_w, hi_w;
  logic [31:0]   dscan, rmw_mask, chk_mask;
  logic [31:0]   lu_has, hit;
  logic [4:0]    lu [32];
  logic [IW-1:0] runlen [32];
  logic          found;
  logic [4:0]    fb;

  function automatic logic [31:0] run_mask(logic [WW-1:0] w, logic [IW-1:0] lo,
                                           logic [IW-1:0] hi_x);
    logic [31:0]   m;
    logic [IW-1:0] g;
    for (int b = 0; b < 32; b++) begin
      g    = {w, 5'(b)};
      m[b] = (g >= lo) && (g < hi_x);
    end
    return m;
  endfunction

  assign eff_ext = IW'(eff_i);
  assign nw_tmp  = eff_ext + IW'(31);
  assign last_w  = nw_tmp[IW-1:5] - WW'(1);
  assign hi      = lo_q + IW'(cnt_q);
  assign hi_m1   = hi - IW'(1);
  assign lo_w    = lo_q[IW-1:5];
  assign hi_w    = hi_m1[IW-1:5];
  assign off_ext = IW'(cmd_i.off);
  assign init_o  = (state_q == S_CLEAR);

  assign rmw_mask = run_mask(w_q, lo_q, hi);
  assign chk_mask = run_mask(rw_q, lo_q, hi);

  // first-fit search over one word; carry_q is the free run ending at the
  // previous word, blocks past the managed count count as used
  always_comb begin
    for (int b = 0; b < 32; b++) begin
      dscan[b] = rdata_q[b] | ({rw_q, 5'(b)} >= eff_ext);
    end
    for (int b = 0; b < 32; b++) begin
      lu_has[b] = 1'b0;
      lu[b]     = '0;
      for (int j = 0; j < 32; j++) begin
        if (j <= b && dscan[j]) begin
          lu_has[b] = 1'b1;
          lu[b]     = 5'(j);
        end
      end
      runlen[b] = lu_has[b] ? IW'(5'(b) - lu[b]) : carry_q + IW'(b + 1);
      hit[b]    = runlen[b] >= IW'(cnt_q);
    end
    found = |hit;
    fb    = '0;
    for (int b = 31; b >= 0; b--) begin
      if (hit[b]) fb = 5'(b);
    end
    run_start = {rw_q, fb} + IW'(1) - IW'(cnt_q);
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) rdata_q <= mem[ra];
  end

  always_comb begin
    state_d = state_q;
    w_d     = w_q;
    rv_d    = 1'b0;
    rw_d    = rw_q;
    carry_d = carry_q;
    lo_d    = lo_q;
    cnt_d   = cnt_q;
    op_d    = op_q;
    used_d  = used_q;
    re      = 1'b0;
    ra      = w_q[AW-1:0];
    we      = 1'b0;
    wa      = w_q[AW-1:0];
    wd      = '0;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o.status        = ST_INVALID;
    res_o.first_block   = '0;
    res_o.granted_count = '0;
    res_o.in_use        = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        we  = 1'b1;
        w_d = w_q + WW'(1);
        if (w_q == WW'(Words - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!cmd_empty_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          op_d      = cmd_i.op;
          cnt_d     = cmd_i.cnt;
          lo_d      = off_ext;
          unique case (cmd_i.op)
            OP_ALLOC: begin
              if (cmd_i.cnt > free_left(eff_i, used_q)) begin
                res_push_o   = 1'b1;
                res_o.status = ST_NOSPACE;
              end else begin
                state_d = S_SCAN;
                w_d     = '0;
                carry_d = '0;
              end
            end
            OP_FREE: begin
              state_d = S_CHECK;
              w_d     = off_ext[IW-1:5];
            end
            OP_QUERY: begin
              re      = 1'b1;
              ra      = off_ext[AW+4:5];
              state_d = S_QUERY;
            end
            default: begin
              res_push_o = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (w_q <= last_w) begin
          re   = 1'b1;
          rv_d = 1'b1;
          rw_d = w_q;
          w_d  = w_q + WW'(1);
        end
        if (rv_q) begin
          if (found) begin
            lo_d    = run_start;
            w_d     = run_start[IW-1:5];
            rv_d    = 1'b0;
            state_d = S_RD;
          end else if (rw_q == last_w) begin
            res_push_o   = 1'b1;
            res_o.status = ST_NOSPACE;
            state_d      = S_IDLE;
          end else begin
            carry_d = lu_has[31] ? IW'(5'd31 - lu[31]) : carry_q + IW'(32);
          end
        end
      end
      S_CHECK: begin
        if (w_q <= hi_w) begin
          re   = 1'b1;
          rv_d = 1'b1;
          rw_d = w_q;
          w_d  = w_q + WW'(1);
        end
        if (rv_q) begin
          if (|(chk_mask & ~rdata_q)) begin
            // double free: leave the map alone
            res_push_o = 1'b1;
            rv_d       = 1'b0;
            state_d    = S_IDLE;
          end else if (rw_q == hi_w) begin
            w_d     = lo_w;
            rv_d    = 1'b0;
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        re      = 1'b1;
        state_d = S_WR;
      end
      S_WR: begin
        we = 1'b1;
        wd = (op_q == OP_ALLOC) ? (rdata_q | rmw_mask) : (rdata_q & ~rmw_mask);
        if (w_q == hi_w) begin
          res_push_o   = 1'b1;
          res_o.status = ST_OK;
          state_d      = S_IDLE;
          if (op_q == OP_ALLOC) begin
            used_d              = used_q + cnt_q;
            res_o.first_block   = base_i + 32'(lo_q);
            res_o.granted_count = cnt_q;
          end else begin
            used_d = (used_q >= cnt_q) ? used_q - cnt_q : '0;
          end
        end else begin
          w_d     = w_q + WW'(1);
          state_d = S_RD;
        end
      end
      S_QUERY: begin
        res_push_o   = 1'b1;
        res_o.status = ST_OK;
        res_o.in_use = rdata_q[lo_q[4:0]];
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    res_o.free_remaining = free_left(eff_i, used_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      w_q     <= '0;
      rv_q    <= 1'b0;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      w_q     <= w_d;
      rv_q    <= rv_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rw_q    <= rw_d;
    carry_q <= carry_d;
    lo_q    <= lo_d;
    cnt_q   <= cnt_d;
    op_q    <= op_d;
  end

endmodule

// ===== sv/bba_checker.sv =====
`timescale 1ns / 1ps
module bba_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input bba_pkg::out_item_t out_item_o
);
  import bba_pkg::*;

  // a waiting beat holds until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("result beat changed while waiting");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.status != ST_OK) |->
      (out_item_o.granted_count == '0 && out_item_o.first_block == '0 &&
       !out_item_o.in_use))
    else $error("failed request carries a grant");

  a_grant_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.granted_count != '0) |-> (out_item_o.status == ST_OK))
    else $error("grant without ok status");

  a_no_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(rst_ni)) |-> empty)
    else $error("result present out of reset");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);
